// ----- sv/kpi_pkg.sv -----
// Shared types and codes for the keyframe position interpolator.
`timescale 1ns / 1ps
package kpi_pkg;
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_INTERP   = 3'd1,
      ST_FIRST    = 3'd2,
      ST_LAST     = 3'd3,
      ST_EMPTY    = 3'd4,
      ST_FULL     = 3'd5,
      ST_ORDER    = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DIV, S_MUL, S_DONE
   } state_type;

   // One key as it travels down the cell chain.
   typedef struct packed {
      logic [31:0] t;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } key_type;
endpackage

// ----- sv/kpi_cell.sv -----
// One key storage cell of the shift chain.
`timescale 1ns / 1ps
module kpi_cell (
   input  logic            clock,
   input  logic            load,
   input  logic            shift,
   input  kpi_pkg::key_type new_key,
   input  kpi_pkg::key_type prev_key,
   output kpi_pkg::key_type key
);
   kpi_pkg::key_type key_ff, key_in;

   always_comb begin
      key_in = key_ff;
      if (load) begin
         key_in = new_key;
      end else if (shift) begin
         key_in = prev_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;
endmodule

// ----- sv/kpi_chain.sv -----
// Row of key cells: appends land at the fill point, a scan rotates the row.
`timescale 1ns / 1ps
module kpi_chain #(
   parameter int MAX_KEYS = 64,
   parameter int CW = $clog2(MAX_KEYS + 1)
) (
   input  logic            clock,
   input  logic            append,
   input  logic [CW-1:0]   count,
   input  logic            rotate,
   input  kpi_pkg::key_type new_key,
   output kpi_pkg::key_type head,
   output kpi_pkg::key_type next
);
   kpi_pkg::key_type keys [MAX_KEYS];

   // rotate: cell i takes cell i+1, the last valid cell takes the head
   for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
      kpi_pkg::key_type from;
      if (i == MAX_KEYS - 1) begin : g_end
         assign from = keys[0];
      end else begin : g_mid
         logic is_tail;
         assign is_tail = (CW'(i) == count - CW'(1));
         assign from = is_tail ? keys[0] : keys[i+1];
      end
      kpi_cell u_cell (
         .clock(clock),
         .load(append && count == CW'(i)),
         .shift(rotate),
         .new_key(new_key),
         .prev_key(from),
         .key(keys[i])
      );
   end

   assign head = keys[0];
   assign next = keys[1];
endmodule

// ----- sv/kpi_arith.sv -----
// Shared restoring divider and sequential multiply for one interpolation.
`timescale 1ns / 1ps
module kpi_arith (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   input  kpi_pkg::key_type lo_key,
   input  kpi_pkg::key_type hi_key,
   output logic        done,
   output logic [31:0] px,
   output logic [31:0] py,
   output logic [31:0] pz
);
   logic        busy_ff, busy_in;
   logic [5:0]  step_ff, step_in;
   logic [32:0] rem_ff, rem_in;
   logic [47:0] q_ff, q_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] r_ff [3];
   logic [31:0] r_in [3];
   kpi_pkg::key_type lo_ff, hi_ff;
   logic [16:0] fac;
   logic signed [32:0] d;
   logic signed [50:0] prod;
   logic [1:0] ax;
   logic [32:0] trial;

   assign fac = (q_ff[47:16] != 32'd0 || q_ff[15:0] == 16'hFFFF) ? 17'hFFFF :
                {1'b0, q_ff[15:0]};
   assign ax = 2'(step_ff - 6'd48);
   always_comb begin
      unique case (ax)
         2'd0: d = $signed({hi_ff.x[31], hi_ff.x}) - $signed({lo_ff.x[31], lo_ff.x});
         2'd1: d = $signed({hi_ff.y[31], hi_ff.y}) - $signed({lo_ff.y[31], lo_ff.y});
         default: d = $signed({hi_ff.z[31], hi_ff.z}) - $signed({lo_ff.z[31], lo_ff.z});
      endcase
   end
   assign prod = 51'(d * $signed({1'b0, fac}));
   assign trial = {rem_ff[31:0], q_ff[47]} - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      den_in = den_ff;
      r_in = r_ff;
      done = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         step_in = 6'd0;
         rem_in = '0;
         q_in = {num, 16'd0};
         den_in = den;
      end else if (busy_ff) begin
         step_in = step_ff + 6'd1;
         if (step_ff < 6'd48) begin
            // one quotient bit per cycle
            if (!trial[32]) begin
               rem_in = trial;
               q_in = {q_ff[46:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], q_ff[47]};
               q_in = {q_ff[46:0], 1'b0};
            end
         end else if (step_ff < 6'd51) begin
            unique case (ax)
               2'd0: r_in[0] = lo_ff.x + 32'(prod >>> 16);
               2'd1: r_in[1] = lo_ff.y + 32'(prod >>> 16);
               default: r_in[2] = lo_ff.z + 32'(prod >>> 16);
            endcase
         end else begin
            busy_in = 1'b0;
            done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      den_ff <= den_in;
      r_ff <= r_in;
      if (start) begin
         lo_ff <= lo_key;
         hi_ff <= hi_key;
      end
   end

   assign px = r_ff[0];
   assign py = r_ff[1];
   assign pz = r_ff[2];
endmodule

// ----- sv/keyframe_position_interpolator.sv -----
// Top level of the keyframe position interpolator.
`timescale 1ns / 1ps
// Usage: req_ carries commands (clear, append, query), one per beat; rsp_
// returns exactly one beat per request, in order. The block takes one request
// at a time.
// Clear, appends (taken or rejected) and empty queries answer straight from idle.
// A query scans the key row by rotating it one cell a cycle for a full lap,
// then a 48-step restoring divide and three multiply steps on the shared
// arithmetic unit; a query held at the first or last key skips the unit.
// Reset empties the table (the count goes to zero); key contents are not
// cleared. While rsp_tready is low the result stays in the output register
// and no new request is taken.
module keyframe_position_interpolator #(
   parameter int MAX_KEYS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata: time_value[31:0], key_x[63:32], key_y[95:64], key_z[127:96]
   input  logic [127:0]  req_tdata,
   // tuser: cmd[1:0]
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], segment[101:96]
   output logic [103:0]  rsp_tdata,
   // tuser: status[2:0]
   output logic [2:0]    rsp_tuser
);
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam int IW = $clog2(MAX_KEYS);

   kpi_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, pos_ff, pos_in;
   logic [IW-1:0] seg_ff, seg_in;
   logic          found_ff, found_in;
   logic [31:0]   qt_ff, qt_in, last_t_ff, last_t_in;
   logic [103:0]  data_ff, data_in;
   logic [2:0]    stat_ff, stat_in;
   kpi_pkg::key_type new_key, head, next, lo_ff, lo_in, hi_ff, hi_in;
   logic          append, rotate, astart, adone;
   logic [31:0]   ax_o, ay_o, az_o;

   assign new_key = '{t: req_tdata[31:0], x: req_tdata[63:32],
                      y: req_tdata[95:64], z: req_tdata[127:96]};

   kpi_chain #(.MAX_KEYS(MAX_KEYS), .CW(CW)) u_chain (
      .clock(clock), .append(append), .count(count_ff), .rotate(rotate),
      .new_key(new_key), .head(head), .next(next));

   kpi_arith u_arith (
      .clock(clock), .reset(reset), .start(astart),
      .num(qt_ff - lo_ff.t), .den(hi_ff.t - lo_ff.t),
      .lo_key(lo_ff), .hi_key(hi_ff), .done(adone),
      .px(ax_o), .py(ay_o), .pz(az_o));

   assign req_tready = (state_ff == kpi_pkg::S_IDLE) && !rsp_tvalid;
   assign rsp_tvalid = (state_ff == kpi_pkg::S_DONE);
   assign rsp_tdata = data_ff;
   assign rsp_tuser = stat_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      seg_in = seg_ff;
      found_in = found_ff;
      qt_in = qt_ff;
      last_t_in = last_t_ff;
      data_in = data_ff;
      stat_in = stat_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      append = 1'b0;
      rotate = 1'b0;
      astart = 1'b0;
      unique case (state_ff)
         kpi_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = kpi_pkg::S_DONE;
               data_in = '0;
               stat_in = kpi_pkg::ST_ACCEPTED;
               unique case (req_tuser)
                  kpi_pkg::CMD_CLEAR: count_in = '0;
                  kpi_pkg::CMD_APPEND: begin
                     if (count_ff == CW'(MAX_KEYS)) begin
                        stat_in = kpi_pkg::ST_FULL;
                     end else if (count_ff != '0 && new_key.t < last_t_ff) begin
                        stat_in = kpi_pkg::ST_ORDER;
                     end else begin
                        append = 1'b1;
                        count_in = count_ff + CW'(1);
                        last_t_in = new_key.t;
                     end
                  end
                  kpi_pkg::CMD_QUERY: begin
                     qt_in = new_key.t;
                     if (count_ff == '0) begin
                        stat_in = kpi_pkg::ST_EMPTY;
                     end else begin
                        state_in = kpi_pkg::S_SCAN;
                        pos_in = '0;
                        found_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         kpi_pkg::S_SCAN: begin
            // head is key pos_ff, next is key pos_ff+1; one lap restores order
            rotate = 1'b1;
            pos_in = pos_ff + CW'(1);
            if (pos_ff == '0 && qt_ff < head.t) begin
               found_in = 1'b1;
               lo_in = head;
               seg_in = '0;
               stat_in = kpi_pkg::ST_FIRST;
            end else if (!found_ff && pos_ff == count_ff - CW'(1)) begin
               found_in = 1'b1;
               lo_in = head;
               seg_in = IW'(pos_ff);
               stat_in = kpi_pkg::ST_LAST;
            end else if (!found_ff && qt_ff < next.t) begin
               found_in = 1'b1;
               lo_in = head;
               hi_in = next;
               seg_in = IW'(pos_ff);
               stat_in = kpi_pkg::ST_INTERP;
            end
            if (pos_ff == count_ff - CW'(1)) begin
               state_in = (stat_in == kpi_pkg::ST_INTERP) ? kpi_pkg::S_DIV :
                          kpi_pkg::S_DONE;
               data_in = {2'b0, 6'(seg_in), lo_in.z, lo_in.y, lo_in.x};
            end
         end
         kpi_pkg::S_DIV: begin
            astart = 1'b1;
            state_in = kpi_pkg::S_MUL;
         end
         kpi_pkg::S_MUL: begin
            if (adone) begin
               data_in = {2'b0, 6'(seg_ff), az_o, ay_o, ax_o};
               state_in = kpi_pkg::S_DONE;
            end
         end
         kpi_pkg::S_DONE: begin
            if (rsp_tready) state_in = kpi_pkg::S_IDLE;
         end
         default: state_in = kpi_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kpi_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff <= pos_in;
      seg_ff <= seg_in;
      found_ff <= found_in;
      qt_ff <= qt_in;
      last_t_ff <= last_t_in;
      data_ff <= data_in;
      stat_ff <= stat_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end
endmodule

// ----- sv/kpi_checker.sv -----
// Port-level checks for the keyframe position interpolator.
`timescale 1ns / 1ps
module kpi_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken in flight");
   a_nopos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == kpi_pkg::ST_ACCEPTED || rsp_tuser == kpi_pkg::ST_EMPTY ||
                     rsp_tuser == kpi_pkg::ST_FULL || rsp_tuser == kpi_pkg::ST_ORDER)
      |-> rsp_tdata == '0)
      else $error("non-query result carries data");
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= kpi_pkg::ST_ORDER)
      else $error("bad status");
endmodule

bind keyframe_position_interpolator kpi_checker u_kpi_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser));

// ----- sim/testbench.sv -----
// Self-checking testbench for the keyframe position interpolator.
`timescale 1ns / 1ps
module testbench;
   localparam int NKEYS = 64;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [31:0] px, py, pz;
      logic [5:0]  seg;
      logic [2:0]  st;
   } pos_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [127:0]  req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;

   keyframe_position_interpolator #(.MAX_KEYS(NKEYS)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state
   logic [31:0] tbl_t [NKEYS];
   logic [31:0] tbl_x [NKEYS];
   logic [31:0] tbl_y [NKEYS];
   logic [31:0] tbl_z [NKEYS];
   int          tbl_count = 0;
   pos_result_type exp_fifo [1024];
   int          exp_wr = 0;
   int          exp_rd = 0;
   int          errors = 0;
   int          cycles = 0;
   bit          rx_stall_long = 0;

   function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b, logic [16:0] f);
      longint s, d, p, r;
      s = longint'(signed'(a));
      d = longint'(signed'(b)) - s;
      p = d * longint'(f);
      r = s + (p >>> 16);
      return r[31:0];
   endfunction

   function automatic pos_result_type predict_key_op(logic [1:0] cmd, logic [127:0] d);
      pos_result_type r;
      logic [31:0] t;
      int idx;
      logic [31:0] dt;
      logic [63:0] num, q;
      logic [16:0] f;
      r = '{32'd0, 32'd0, 32'd0, 6'd0, kpi_pkg::ST_ACCEPTED};
      t = d[31:0];
      if (cmd == kpi_pkg::CMD_CLEAR) begin
         tbl_count = 0;
      end else if (cmd == kpi_pkg::CMD_APPEND) begin
         if (tbl_count >= NKEYS) r.st = kpi_pkg::ST_FULL;
         else if (tbl_count > 0 && t < tbl_t[tbl_count-1]) r.st = kpi_pkg::ST_ORDER;
         else begin
            tbl_t[tbl_count] = t;
            tbl_x[tbl_count] = d[63:32];
            tbl_y[tbl_count] = d[95:64];
            tbl_z[tbl_count] = d[127:96];
            tbl_count++;
         end
      end else if (cmd == kpi_pkg::CMD_QUERY) begin
         if (tbl_count == 0) r.st = kpi_pkg::ST_EMPTY;
         else if (t < tbl_t[0]) begin
            r.px = tbl_x[0]; r.py = tbl_y[0]; r.pz = tbl_z[0]; r.st = kpi_pkg::ST_FIRST;
         end else begin
            idx = tbl_count - 1;
            for (int i = 1; i < tbl_count; i++)
               if (t < tbl_t[i]) begin
                  idx = i - 1;
                  break;
               end
            r.seg = idx[5:0];
            if (idx + 1 >= tbl_count) begin
               r.px = tbl_x[idx]; r.py = tbl_y[idx]; r.pz = tbl_z[idx];
               r.st = kpi_pkg::ST_LAST;
            end else begin
               dt = tbl_t[idx+1] - tbl_t[idx];
               num = {32'd0, t - tbl_t[idx]} << 16;
               q = (dt != 0) ? num / dt : 64'd0;
               f = (q > 64'd65535) ? 17'd65535 : q[16:0];
               r.px = lerp(tbl_x[idx], tbl_x[idx+1], f);
               r.py = lerp(tbl_y[idx], tbl_y[idx+1], f);
               r.pz = lerp(tbl_z[idx], tbl_z[idx+1], f);
               r.st = kpi_pkg::ST_INTERP;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
   endtask

   function automatic int gap_len();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   // Send one beat; the prediction is queued when it is accepted.
   task automatic send_beat(logic [1:0] cmd, logic [127:0] d, bit idle = 1);
      int n;
      n = idle ? gap_len() : 0;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      exp_fifo[exp_wr[9:0]] = predict_key_op(cmd, d);
      exp_wr++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rnd_pos();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [127:0] key_beat(logic [31:0] t);
      return {rnd_pos(), rnd_pos(), rnd_pos(), t};
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (exp_wr != exp_rd) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Checker: compare each accepted result beat with the oldest prediction
   always @(posedge clock) begin
      pos_result_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_wr == exp_rd) begin
            report_mismatch("unexpected beat", 32'(rsp_tuser), 32'd0);
         end else begin
            w = exp_fifo[exp_rd[9:0]];
            exp_rd++;
            if (rsp_tdata[31:0] !== w.px) report_mismatch("pos_x", rsp_tdata[31:0], w.px);
            if (rsp_tdata[63:32] !== w.py) report_mismatch("pos_y", rsp_tdata[63:32], w.py);
            if (rsp_tdata[95:64] !== w.pz) report_mismatch("pos_z", rsp_tdata[95:64], w.pz);
            if (rsp_tdata[101:96] !== w.seg)
               report_mismatch("segment", 32'(rsp_tdata[101:96]), 32'(w.seg));
            if (rsp_tuser !== w.st) report_mismatch("status", 32'(rsp_tuser), 32'(w.st));
         end
      end
   end

   // Receiver back-pressure
   initial begin
      int n;
      @(negedge clock);
      forever begin
         rsp_tready <= 1'b1;
         n = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(1, 20);
         repeat (n) @(negedge clock);
         n = gap_len();
         if (!rx_stall_long && n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_directed();
      send_beat(kpi_pkg::CMD_QUERY, 128'd5);
      send_beat(kpi_pkg::CMD_APPEND,
                {32'h80000000, 32'h7FFFFFFF, 32'h00010000, 32'h00010000});
      send_beat(kpi_pkg::CMD_QUERY, 128'd0);              // before first
      send_beat(kpi_pkg::CMD_QUERY, 128'h00010000);       // single key
      send_beat(kpi_pkg::CMD_QUERY, 128'hFFFFFFFF);
      send_beat(kpi_pkg::CMD_APPEND,
                {32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000, 32'h00020000});
      send_beat(kpi_pkg::CMD_APPEND, {32'd1, 32'd2, 32'd3, 32'h00020000}); // equal time
      send_beat(kpi_pkg::CMD_APPEND, key_beat(32'h00008000));      // out of order
      send_beat(kpi_pkg::CMD_QUERY, 128'h00018000);
      send_beat(kpi_pkg::CMD_QUERY, 128'h0001FFFF);
      send_beat(kpi_pkg::CMD_QUERY, 128'h00020000);
      send_beat(kpi_pkg::CMD_APPEND, key_beat(32'hFFFFFFFF));
      send_beat(kpi_pkg::CMD_QUERY, 128'h80000000);
      send_beat(kpi_pkg::CMD_UNUSED,
                {32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
      send_beat(kpi_pkg::CMD_CLEAR, '1);
      send_beat(kpi_pkg::CMD_QUERY, 128'd0);
   endtask

   task automatic test_full_table();
      send_beat(kpi_pkg::CMD_CLEAR, '0);
      for (int i = 0; i < NKEYS; i++)
         send_beat(kpi_pkg::CMD_APPEND, key_beat(32'(i) << 12), 0);
      send_beat(kpi_pkg::CMD_APPEND, key_beat(32'd0));    // full and out of order
      send_beat(kpi_pkg::CMD_APPEND, key_beat(32'hFFFFFFFF));
      send_beat(kpi_pkg::CMD_QUERY, 128'(32'(NKEYS - 1) << 12));
      send_beat(kpi_pkg::CMD_QUERY, 128'h00018800);
   endtask

   task automatic test_random();
      int done, nk;
      logic [31:0] t;
      done = 0;
      while (done < 400) begin
         send_beat(kpi_pkg::CMD_CLEAR, {$urandom, $urandom, $urandom, $urandom});
         nk = ($urandom_range(0, 9) == 0) ? $urandom_range(20, NKEYS + 2) :
              $urandom_range(1, 6);
         t = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 32'h00100000);
         for (int i = 0; i < nk; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(kpi_pkg::CMD_APPEND, key_beat(t - $urandom_range(1, 4)));
            else begin
               t = t + (($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(1, 32'h00040000));
               send_beat(kpi_pkg::CMD_APPEND, key_beat(t));
            end
            done++;
         end
         repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 4))
               0: send_beat(kpi_pkg::CMD_QUERY, 128'($urandom));
               1: send_beat(kpi_pkg::CMD_UNUSED, {$urandom, $urandom, $urandom, $urandom});
               default: send_beat(kpi_pkg::CMD_QUERY,
                                  128'($urandom_range(0, t + 32'h00010000)));
            endcase
            done++;
         end
      end
   endtask

   task automatic test_paused();
      rx_stall_long = 1;
      send_beat(kpi_pkg::CMD_QUERY, 128'($urandom));
      drain();
      send_beat(kpi_pkg::CMD_QUERY, 128'($urandom));
      rx_stall_long = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_paused();
      test_random();
      drain();
      repeat (100) @(negedge clock);
      if (errors == 0 && exp_wr == exp_rd) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ----- files.f -----
sv/kpi_pkg.sv
sv/kpi_cell.sv
sv/kpi_chain.sv
sv/kpi_arith.sv
sv/keyframe_position_interpolator.sv
sv/kpi_checker.sv
sim/testbench.sv
